// ===== sv/rlfs_pkg.sv =====
`default_nettype none

package rlfs_pkg;

  // Default strip length; the store holds one 24-bit word per pixel.
  localparam int MAX_PIXELS_DEF = 1024;

  // Width used for pixel comparisons: covers the 11-bit count register and any
  // supported store depth.
  localparam int CMP_W = 17;

  localparam int PIXEL_W = 24;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [15:0] LATCH_TICKS_RST = 16'd1000;

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_START = 2'd1;
  localparam logic [1:0] FN_TICK  = 2'd2;

  localparam logic [1:0] REG_PIXEL_COUNT = 2'd0;
  localparam logic [1:0] REG_COLOR_ORDER = 2'd1;
  localparam logic [1:0] REG_LATCH_TICKS = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SHIFT,
    PH_LATCH
  } phase_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_READY,
    ST_FETCH
  } eng_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  pixel_index;
    logic [23:0] rgb_color;
  } in_t;

  typedef struct packed {
    logic data_out;
    logic clk_pulse;
    logic busy_res;
    logic frame_done;
    logic refused;
  } out_t;

  typedef struct packed {
    logic [10:0] pixel_count;
    logic        color_order;
    logic [15:0] latch_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/rgb_led_strip_frame_shifter_core.sv =====
// Channel  Direction  Payload              Accepted when
// in       input      rlfs_pkg::in_t       in_valid && !in_stall
// out      output     rlfs_pkg::out_t      out_valid && !out_stall
// apb      input      pixel_count, color_order, latch_ticks at 0x0, 0x4, 0x8
//
// Write, start, idle and latch ticks are answered directly from the READY state; a shift tick
// passes through the FETCH state first, since the pixel word is read from the single-port-read frame store.
// After reset the frame store is cleared one pixel per cycle, through all MAX_PIXELS entries,
// while in_stall stays high; register writes are taken meanwhile.
// A new item is taken while the previous result sits in the output register,
// provided that register is being emptied in the same cycle.
`default_nettype none

module rgb_led_strip_frame_shifter_core #(
  parameter int MAX_PIXELS = rlfs_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire rlfs_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output rlfs_pkg::out_t                      out_data,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rlfs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [rlfs_pkg::PDATA_W-1:0]   pwdata,
  output logic [rlfs_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  rlfs_pkg::cfg_t               cfg;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [rlfs_pkg::PIXEL_W-1:0] ram_wdata, ram_rdata;
  logic                         cfg_write;
  logic [1:0]                   reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_count <= 11'd0;
      cfg.color_order <= 1'b0;
      cfg.latch_ticks <= rlfs_pkg::LATCH_TICKS_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        rlfs_pkg::REG_PIXEL_COUNT: cfg.pixel_count <= pwdata[10:0];
        rlfs_pkg::REG_COLOR_ORDER: cfg.color_order <= pwdata[0];
        rlfs_pkg::REG_LATCH_TICKS: cfg.latch_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rlfs_pkg::REG_PIXEL_COUNT: prdata = {21'd0, cfg.pixel_count};
      rlfs_pkg::REG_COLOR_ORDER: prdata = {31'd0, cfg.color_order};
      rlfs_pkg::REG_LATCH_TICKS: prdata = {16'd0, cfg.latch_ticks};
      default:                   prdata = '0;
    endcase
  end

  rlfs_engine #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  rlfs_ram #(
    .WIDTH(rlfs_pkg::PIXEL_W),
    .DEPTH(MAX_PIXELS)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== sv/rlfs_ram.sv =====
`default_nettype none

module rlfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/rlfs_engine.sv =====
`default_nettype none

module rlfs_engine #(
  parameter int MAX_PIXELS = rlfs_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst,
  input  wire rlfs_pkg::cfg_t                                    cfg,
  input  wire logic                                              in_valid,
  output logic                                                   in_stall,
  input  wire rlfs_pkg::in_t                                     in_data,
  output logic                                                   out_valid,
  input  wire logic                                              out_stall,
  output rlfs_pkg::out_t                                         out_data,
  output logic                                                   ram_we,
  output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] ram_waddr,
  output logic [rlfs_pkg::PIXEL_W-1:0]                           ram_wdata,
  output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] ram_raddr,
  input  wire logic [rlfs_pkg::PIXEL_W-1:0]                      ram_rdata
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int PW = $clog2(MAX_PIXELS + 1);
  localparam int CW = rlfs_pkg::CMP_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_PIXELS - 1);
  localparam logic [CW-1:0] MAX_EXT  = CW'(MAX_PIXELS);

  rlfs_pkg::eng_state_t st, st_next;
  rlfs_pkg::phase_t     phase, phase_next;
  logic [AW-1:0]        clr_addr;
  logic [PW-1:0]        pixel_ptr, pixel_ptr_next;
  logic [1:0]           byte_sel, byte_sel_next;
  logic [2:0]           bit_ptr, bit_ptr_next;
  logic [15:0]          latch_cnt, latch_cnt_next;
  logic                 data_level, data_level_next;
  rlfs_pkg::out_t       res;
  logic                 load_out;

  logic          accept;
  logic [CW-1:0] count_ext, active, idx_ext, ptr_ext, ptr_inc_ext;
  logic [PW-1:0] ptr_inc;
  logic [15:0]   latch_len, latch_dec;
  logic [7:0]    cur_byte;

  assign in_stall = !((st == rlfs_pkg::ST_READY) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;

  // Effective pixel count: values above the store depth act as the depth.
  assign count_ext   = {{(CW - 11){1'b0}}, cfg.pixel_count};
  assign active      = (count_ext > MAX_EXT) ? MAX_EXT : count_ext;
  assign idx_ext     = {{(CW - 10){1'b0}}, in_data.pixel_index};
  assign ptr_ext     = {{(CW - PW){1'b0}}, pixel_ptr};
  assign ptr_inc     = pixel_ptr + 1'b1;
  assign ptr_inc_ext = {{(CW - PW){1'b0}}, ptr_inc};
  assign latch_len   = (cfg.latch_ticks == 16'd0) ? 16'd1 : cfg.latch_ticks;
  assign latch_dec   = (latch_cnt != 16'd0) ? (latch_cnt - 16'd1) : 16'd0;
  assign ram_raddr   = pixel_ptr[AW-1:0];

  always_comb begin
    case (byte_sel)
      2'd0:    cur_byte = ram_rdata[23:16];
      2'd1:    cur_byte = ram_rdata[15:8];
      default: cur_byte = ram_rdata[7:0];
    endcase
  end

  // Next state.
  always_comb begin
    st_next = st;
    case (st)
      rlfs_pkg::ST_CLEAR: begin
        if (clr_addr == CLR_LAST) begin
          st_next = rlfs_pkg::ST_READY;
        end
      end
      rlfs_pkg::ST_READY: begin
        if (accept && (in_data.func == rlfs_pkg::FN_TICK) && (phase == rlfs_pkg::PH_SHIFT)) begin
          st_next = rlfs_pkg::ST_FETCH;
        end
      end
      rlfs_pkg::ST_FETCH: st_next = rlfs_pkg::ST_READY;
      default:            st_next = rlfs_pkg::ST_CLEAR;
    endcase
  end

  // Datapath and result.
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = idx_ext[AW-1:0];
    ram_wdata       = cfg.color_order
                      ? {in_data.rgb_color[15:8], in_data.rgb_color[23:16], in_data.rgb_color[7:0]}
                      : in_data.rgb_color;
    phase_next      = phase;
    pixel_ptr_next  = pixel_ptr;
    byte_sel_next   = byte_sel;
    bit_ptr_next    = bit_ptr;
    latch_cnt_next  = latch_cnt;
    data_level_next = data_level;
    load_out        = 1'b0;
    res             = '0;
    case (st)
      rlfs_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      rlfs_pkg::ST_READY: begin
        if (accept) begin
          load_out = 1'b1;
          case (in_data.func)
            rlfs_pkg::FN_WRITE: begin
              if ((phase != rlfs_pkg::PH_IDLE) || (idx_ext >= active)) begin
                res.refused = 1'b1;
              end else begin
                ram_we = 1'b1;
              end
            end
            rlfs_pkg::FN_START: begin
              if (phase != rlfs_pkg::PH_IDLE) begin
                res.refused = 1'b1;
              end else begin
                pixel_ptr_next = '0;
                byte_sel_next  = 2'd0;
                bit_ptr_next   = 3'd7;
                if (active == '0) begin
                  phase_next     = rlfs_pkg::PH_LATCH;
                  latch_cnt_next = latch_len;
                end else begin
                  phase_next = rlfs_pkg::PH_SHIFT;
                end
              end
            end
            rlfs_pkg::FN_TICK: begin
              case (phase)
                rlfs_pkg::PH_SHIFT: begin
                  // The bit comes out of the store in the next cycle, from the FETCH state.
                  load_out = 1'b0;
                end
                rlfs_pkg::PH_LATCH: begin
                  latch_cnt_next = latch_dec;
                  if (latch_dec == 16'd0) begin
                    phase_next      = rlfs_pkg::PH_IDLE;
                    pixel_ptr_next  = '0;
                    byte_sel_next   = 2'd0;
                    bit_ptr_next    = 3'd7;
                    res.frame_done  = 1'b1;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      rlfs_pkg::ST_FETCH: begin
        load_out = 1'b1;
        if (ptr_ext >= active) begin
          // The strip was shortened under a running frame: latch without a pulse.
          phase_next     = rlfs_pkg::PH_LATCH;
          latch_cnt_next = latch_len;
        end else begin
          data_level_next = cur_byte[bit_ptr];
          res.clk_pulse   = 1'b1;
          if (bit_ptr == 3'd0) begin
            bit_ptr_next = 3'd7;
            if (byte_sel == 2'd2) begin
              byte_sel_next  = 2'd0;
              pixel_ptr_next = ptr_inc;
              if (ptr_inc_ext >= active) begin
                phase_next     = rlfs_pkg::PH_LATCH;
                latch_cnt_next = latch_len;
              end
            end else begin
              byte_sel_next = byte_sel + 2'd1;
            end
          end else begin
            bit_ptr_next = bit_ptr - 3'd1;
          end
        end
      end
      default: ;
    endcase
    res.data_out = data_level_next;
    res.busy_res = (phase_next != rlfs_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= rlfs_pkg::ST_CLEAR;
      clr_addr   <= '0;
      phase      <= rlfs_pkg::PH_IDLE;
      pixel_ptr  <= '0;
      byte_sel   <= 2'd0;
      bit_ptr    <= 3'd7;
      latch_cnt  <= 16'd0;
      data_level <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      st         <= st_next;
      phase      <= phase_next;
      pixel_ptr  <= pixel_ptr_next;
      byte_sel   <= byte_sel_next;
      bit_ptr    <= bit_ptr_next;
      latch_cnt  <= latch_cnt_next;
      data_level <= data_level_next;
      if (st == rlfs_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rlfs_checker.sv =====
`default_nettype none

module rlfs_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire rlfs_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire rlfs_pkg::out_t out_data
);

  // The frame store is being cleared right after reset, so no item is taken.
  a_stall_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("item channel open right after reset");

  // The last latch tick ends the frame, so the block is no longer busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_done) |-> !out_data.busy_res)
    else $error("frame_done raised while still busy");

  // A clock pulse comes only from a running frame, which is still busy after it.
  a_pulse_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.clk_pulse) |-> (out_data.busy_res && !out_data.refused &&
                                           !out_data.frame_done))
    else $error("clock pulse outside a running frame");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

bind rgb_led_strip_frame_shifter_core rlfs_checker u_rlfs_checker (.*);

`default_nettype wire
